// ----- hw/rtl/hie_pkg.sv -----
package hie_pkg;

    localparam int DEFAULT_COORD_BITS = 16;
    localparam int INDEX_WIDTH        = 48;
    localparam int DIMS_WIDTH         = 2;

    localparam logic [DIMS_WIDTH-1:0] DIMS_TWO   = 2'd2;
    localparam logic [DIMS_WIDTH-1:0] DIMS_THREE = 2'd3;

    localparam logic REG_DIMENSION_COUNT = 1'b0;

endpackage

// ----- hw/rtl/hie_cell.sv -----
module hie_cell
    import hie_pkg::*;
#(
    parameter int COORD_BITS = DEFAULT_COORD_BITS,
    parameter int LEVEL      = COORD_BITS - 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  logic                  three_d,
    input  logic                  in_valid,
    input  logic [COORD_BITS-1:0] in_x,
    input  logic [COORD_BITS-1:0] in_y,
    input  logic [COORD_BITS-1:0] in_z,
    output logic                  out_valid,
    output logic [COORD_BITS-1:0] out_x,
    output logic [COORD_BITS-1:0] out_y,
    output logic [COORD_BITS-1:0] out_z
);

    localparam logic [COORD_BITS-1:0] LOW_MASK =
        {{(COORD_BITS-LEVEL){1'b0}}, {LEVEL{1'b1}}};

    logic                  valid_reg;
    logic [COORD_BITS-1:0] x_reg, y_reg, z_reg;
    logic [COORD_BITS-1:0] x_next, y_next, z_next;

    always_comb begin
        logic [COORD_BITS-1:0] t;
        t      = '0;
        x_next = in_x;
        y_next = in_y;
        z_next = in_z;
        if (x_next[LEVEL]) begin
            x_next = x_next ^ LOW_MASK;
        end
        if (y_next[LEVEL]) begin
            x_next = x_next ^ LOW_MASK;
        end else begin
            t      = (x_next ^ y_next) & LOW_MASK;
            x_next = x_next ^ t;
            y_next = y_next ^ t;
        end
        if (three_d) begin
            if (z_next[LEVEL]) begin
                x_next = x_next ^ LOW_MASK;
            end else begin
                t      = (x_next ^ z_next) & LOW_MASK;
                x_next = x_next ^ t;
                z_next = z_next ^ t;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;

endmodule

// ----- hw/rtl/hie_finish.sv -----
module hie_finish
    import hie_pkg::*;
#(
    parameter int COORD_BITS = DEFAULT_COORD_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   advance,
    input  logic                   three_d,
    input  logic                   in_valid,
    input  logic [COORD_BITS-1:0]  in_x,
    input  logic [COORD_BITS-1:0]  in_y,
    input  logic [COORD_BITS-1:0]  in_z,
    output logic                   out_valid,
    output logic [INDEX_WIDTH-1:0] out_index
);

    localparam int CODE_W = (3 * COORD_BITS > INDEX_WIDTH) ? 3 * COORD_BITS : INDEX_WIDTH;

    logic                   valid_reg;
    logic [INDEX_WIDTH-1:0] index_reg;
    logic [INDEX_WIDTH-1:0] index_next;
    logic [COORD_BITS-1:0]  gx, gy, gz, last, corr;
    logic [CODE_W-1:0]      code2, code3;

    always_comb begin
        gx   = in_x;
        gy   = in_y ^ in_x;
        gz   = in_z ^ gy;
        last = three_d ? gz : gy;
        for (int i = 0; i < COORD_BITS; i++) begin
            corr[i] = ^(last >> (i + 1));
        end
        gx = gx ^ corr;
        gy = gy ^ corr;
        gz = gz ^ corr;
        code2 = '0;
        code3 = '0;
        for (int b = 0; b < COORD_BITS; b++) begin
            code2[2*b+1] = gx[b];
            code2[2*b]   = gy[b];
            code3[3*b+2] = gx[b];
            code3[3*b+1] = gy[b];
            code3[3*b]   = gz[b];
        end
        index_next = three_d ? code3[INDEX_WIDTH-1:0] : code2[INDEX_WIDTH-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            index_reg <= index_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_index = index_reg;

endmodule

// ----- hw/rtl/hilbert_index_encoder.sv -----
// Throughput: one point per cycle unless m_ready stalls the output; one pipeline cell per undo level, COORD_BITS-1
// cells, then a Gray/correction/interleave stage with the output register.
// The whole pipeline holds while a result waits on m_ready.
// Reset: synchronous, active low; clears all valid bits, dimension_count to 2.
module hilbert_index_encoder
    import hie_pkg::*;
#(
    parameter int COORD_BITS = DEFAULT_COORD_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [COORD_BITS-1:0]  s_coord_x,
    input  logic [COORD_BITS-1:0]  s_coord_y,
    input  logic [COORD_BITS-1:0]  s_coord_z,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [INDEX_WIDTH-1:0] m_curve_index
);

    logic [DIMS_WIDTH-1:0] dims_reg;
    logic                  three_d;
    logic                  advance;

    logic                  stage_valid [0:COORD_BITS-1];
    logic [COORD_BITS-1:0] stage_x     [0:COORD_BITS-1];
    logic [COORD_BITS-1:0] stage_y     [0:COORD_BITS-1];
    logic [COORD_BITS-1:0] stage_z     [0:COORD_BITS-1];

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dims_reg <= DIMS_TWO;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == REG_DIMENSION_COUNT) begin
            dims_reg <= pwdata[DIMS_WIDTH-1:0];
        end
    end

    assign prdata  = (paddr[2] == REG_DIMENSION_COUNT) ?
                     {{(32-DIMS_WIDTH){1'b0}}, dims_reg} : 32'd0;
    assign three_d = (dims_reg == DIMS_THREE);
    assign advance = !m_valid || m_ready;
    assign s_ready = advance;

    assign stage_valid[0] = s_valid;
    assign stage_x[0]     = s_coord_x;
    assign stage_y[0]     = s_coord_y;
    assign stage_z[0]     = s_coord_z;

    for (genvar i = 0; i < COORD_BITS - 1; i++) begin : g_cell
        hie_cell #(
            .COORD_BITS(COORD_BITS),
            .LEVEL     (COORD_BITS - 1 - i)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .three_d  (three_d),
            .in_valid (stage_valid[i]),
            .in_x     (stage_x[i]),
            .in_y     (stage_y[i]),
            .in_z     (stage_z[i]),
            .out_valid(stage_valid[i+1]),
            .out_x    (stage_x[i+1]),
            .out_y    (stage_y[i+1]),
            .out_z    (stage_z[i+1])
        );
    end

    hie_finish #(
        .COORD_BITS(COORD_BITS)
    ) u_finish (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .three_d  (three_d),
        .in_valid (stage_valid[COORD_BITS-1]),
        .in_x     (stage_x[COORD_BITS-1]),
        .in_y     (stage_y[COORD_BITS-1]),
        .in_z     (stage_z[COORD_BITS-1]),
        .out_valid(m_valid),
        .out_index(m_curve_index)
    );

`ifndef SYNTHESIS
    a_two_d_upper_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !three_d |-> (m_curve_index >> (2 * COORD_BITS)) == '0)
        else $error("upper index bits set in two-axis mode");

    a_reset_clears_output: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");

    a_accept_enters_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> stage_valid[1] || (COORD_BITS == 1))
        else $error("accepted transaction missing from first cell");
`endif

endmodule
